// ===== rtl/core/clla_pkg.sv =====
package clla_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int RAD_W     = 31;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int D2_W      = PROD_W + 1;
  localparam int DABS_W    = PROD_W;
  localparam int RADIC_W   = 128;
  localparam int ROOT_W    = RADIC_W / 2;
  localparam int NUM_W     = 102;
  localparam int Q_W       = 34;
  localparam int PT_W      = Q_W + 1;
  localparam int EX_W      = PT_W + 1;
  localparam int SQD_W     = 2 * EX_W;

  localparam logic [RAD_W-1:0]   RADIUS_RESET = RAD_W'(786432);
  localparam logic [COORD_W-1:0] MISS_POINT   = COORD_W'(-(99 << FRAC_BITS));

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] robot_x;
    logic signed [COORD_W-1:0] robot_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      hit;
  } out_item_t;

  typedef struct packed {
    logic [D2_W-1:0]    d;
    logic [DABS_W-1:0]  dabs;
    logic [DIFF_W-1:0]  dx;
    logic [DIFF_W-1:0]  dy;
    logic [DIFF_W-1:0]  adx;
    logic [DIFF_W-1:0]  ady;
    logic [DIFF_W-1:0]  p2x;
    logic [DIFF_W-1:0]  p2y;
    logic [D2_W-1:0]    d2;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic               miss;
  } geo_t;

  typedef struct packed {
    logic [D2_W-1:0]    d2;
    logic [DIFF_W-1:0]  p2x;
    logic [DIFF_W-1:0]  p2y;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic               miss;
  } div_t;

endpackage

// ===== rtl/core/circle_line_lookahead_point_core.sv =====
// Lookahead point search for path following: one path segment per item.
// Input channel (in_valid, in_stall, in_item) carries segment start, segment
// end and robot position, signed Q16.16. The line through the segment is cut
// with a circle of radius lookahead_radius around the robot; the result item
// (out_valid, out_stall, out_item) gives the intersection nearer the segment
// end and hit = 1, or hit = 0 and the point (-99, -99) when the line misses
// or the segment has zero length.
// The radius register is written with cfg_wr_en / cfg_wr_data; it must be
// written only while idle, which the block itself does not enforce. From
// acceptance to out_valid an item passes differences, products and discriminant,
// 64 square-root steps (two radicand bits per stage), numerators, 34
// restoring-division steps (four lanes in parallel, one quotient bit
// per stage), root choice and output; one item per cycle unless stalled.
// When out_stall holds a waiting result, every stage holds and in_stall is
// raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets the radius to 12.0.
module circle_line_lookahead_point_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  clla_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output clla_pkg::out_item_t           out_item,
  input  logic                          cfg_wr_en,
  input  logic [clla_pkg::RAD_W-1:0]    cfg_wr_data
);

  localparam int DW  = clla_pkg::DIFF_W;
  localparam int PW  = clla_pkg::PROD_W;
  localparam int D2W = clla_pkg::D2_W;
  localparam int RW  = clla_pkg::ROOT_W;
  localparam int NW  = clla_pkg::NUM_W;
  localparam int QW  = clla_pkg::Q_W;
  localparam int RDW = 130;
  localparam int DDW = 132;
  localparam int DCW = 133;

  logic adv;
  logic [clla_pkg::RAD_W-1:0] radius;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= clla_pkg::RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  // valid bits
  logic [6:0]  sv;
  logic [RW:1] sq_v;
  logic [2:0]  mv;
  logic [QW:0] dv_v;
  logic [3:0]  cv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv   <= '0;
      sq_v <= '0;
      mv   <= '0;
      dv_v <= '0;
      cv   <= '0;
    end else if (adv) begin
      sv   <= {sv[5:0], in_valid};
      sq_v <= {sq_v[RW-1:1], sv[6]};
      mv   <= {mv[1:0], sq_v[RW]};
      dv_v <= {dv_v[QW-1:0], mv[2]};
      cv   <= {cv[2:0], dv_v[QW]};
    end
  end

  // front: differences, products, discriminant
  logic [DW-1:0] s1_p1x, s1_p1y, s1_p2x, s1_p2y, s1_dx, s1_dy;
  logic [31:0]   s1_rx, s1_ry;
  logic [clla_pkg::RAD_W-1:0] s1_r;
  logic [PW-1:0] s2_dx2, s2_dy2, s2_a, s2_b;
  logic [61:0]   s2_r2;
  logic [DW-1:0] s2_dx, s2_dy, s2_adx, s2_ady, s2_p2x, s2_p2y;
  logic [31:0]   s2_rx, s2_ry;
  logic [61:0]   s3_r2;
  clla_pkg::geo_t s3_g, s4_g, s5_g, s6_g;
  clla_pkg::geo_t s4_g_next, g0_next;
  logic [64:0]   s4_rhh, s4_rhl, s4_rlh, s4_rll;
  logic [RDW-1:0] s5_rd, s6_rd;
  logic [PW-1:0] s5_dhh, s5_dhl, s5_dll;
  logic [DDW-1:0] s6_dd;
  logic [DCW-1:0] disc;
  logic [D2W-1:0] d3;

  assign d3   = D2W'($signed(s2_a)) - D2W'($signed(s2_b));
  assign disc = DCW'(s6_rd) - DCW'(s6_dd);

  always_comb begin
    s4_g_next      = s3_g;
    s4_g_next.dabs = s3_g.d[D2W-1] ? PW'(D2W'(0) - s3_g.d) : s3_g.d[PW-1:0];
  end

  always_comb begin
    g0_next      = s6_g;
    g0_next.miss = disc[DCW-1] || (s6_g.d2 == '0);
  end

  logic [RW+1:0]       sq_rem  [0:RW];
  logic [RW-1:0]       sq_root [0:RW];
  logic [clla_pkg::RADIC_W-1:0] sq_n [0:RW];
  clla_pkg::geo_t      sq_geo  [0:RW];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p1x <= {in_item.start_x[31], in_item.start_x} - {in_item.robot_x[31], in_item.robot_x};
      s1_p1y <= {in_item.start_y[31], in_item.start_y} - {in_item.robot_y[31], in_item.robot_y};
      s1_p2x <= {in_item.end_x[31], in_item.end_x} - {in_item.robot_x[31], in_item.robot_x};
      s1_p2y <= {in_item.end_y[31], in_item.end_y} - {in_item.robot_y[31], in_item.robot_y};
      s1_dx  <= {in_item.end_x[31], in_item.end_x} - {in_item.start_x[31], in_item.start_x};
      s1_dy  <= {in_item.end_y[31], in_item.end_y} - {in_item.start_y[31], in_item.start_y};
      s1_rx  <= in_item.robot_x;
      s1_ry  <= in_item.robot_y;
      s1_r   <= radius;

      s2_dx2 <= PW'($signed(s1_dx)) * PW'($signed(s1_dx));
      s2_dy2 <= PW'($signed(s1_dy)) * PW'($signed(s1_dy));
      s2_a   <= PW'($signed(s1_p1x)) * PW'($signed(s1_p2y));
      s2_b   <= PW'($signed(s1_p2x)) * PW'($signed(s1_p1y));
      s2_r2  <= 62'(s1_r) * 62'(s1_r);
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;
      s2_adx <= s1_dx[DW-1] ? DW'(0) - s1_dx : s1_dx;
      s2_ady <= s1_dy[DW-1] ? DW'(0) - s1_dy : s1_dy;
      s2_p2x <= s1_p2x;
      s2_p2y <= s1_p2y;
      s2_rx  <= s1_rx;
      s2_ry  <= s1_ry;

      s3_r2       <= s2_r2;
      s3_g.d      <= d3;
      s3_g.dabs   <= '0;
      s3_g.dx     <= s2_dx;
      s3_g.dy     <= s2_dy;
      s3_g.adx    <= s2_adx;
      s3_g.ady    <= s2_ady;
      s3_g.p2x    <= s2_p2x;
      s3_g.p2y    <= s2_p2y;
      s3_g.d2     <= D2W'(s2_dx2) + D2W'(s2_dy2);
      s3_g.rx     <= s2_rx;
      s3_g.ry     <= s2_ry;
      s3_g.miss   <= 1'b0;

      s4_g   <= s4_g_next;
      s4_rhh <= 65'(s3_r2[61:31]) * 65'(s3_g.d2[66:33]);
      s4_rhl <= 65'(s3_r2[61:31]) * 65'(s3_g.d2[32:0]);
      s4_rlh <= 65'(s3_r2[30:0]) * 65'(s3_g.d2[66:33]);
      s4_rll <= 65'(s3_r2[30:0]) * 65'(s3_g.d2[32:0]);

      s5_g   <= s4_g;
      s5_rd  <= (RDW'(s4_rhh) << 64) + (RDW'(s4_rhl) << 31) + (RDW'(s4_rlh) << 33)
              + RDW'(s4_rll);
      s5_dhh <= PW'(s4_g.dabs[65:33]) * PW'(s4_g.dabs[65:33]);
      s5_dhl <= PW'(s4_g.dabs[65:33]) * PW'(s4_g.dabs[32:0]);
      s5_dll <= PW'(s4_g.dabs[32:0]) * PW'(s4_g.dabs[32:0]);

      s6_g   <= s5_g;
      s6_rd  <= s5_rd;
      s6_dd  <= (DDW'(s5_dhh) << 66) + (DDW'(s5_dhl) << 34) + DDW'(s5_dll);

      sq_geo[0]  <= g0_next;
      sq_n[0]    <= g0_next.miss ? '0 : disc[clla_pkg::RADIC_W-1:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // square root, two radicand bits per stage
  for (genvar k = 0; k < RW; k++) begin : g_root
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    assign cur   = {sq_rem[k], sq_n[k][clla_pkg::RADIC_W-1 -: 2]};
    assign trial = {2'b00, sq_root[k], 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n[k+1]   <= sq_n[k] << 2;
        sq_geo[k+1] <= sq_geo[k];
        if (cur >= trial) begin
          sq_rem[k+1]  <= (RW+2)'(cur - trial);
          sq_root[k+1] <= {sq_root[k][RW-2:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= cur[RW+1:0];
          sq_root[k+1] <= {sq_root[k][RW-2:0], 1'b0};
        end
      end
    end
  end

  // numerators
  clla_pkg::geo_t m1_g, m2_g, m3_g;
  logic [64:0] m1_txl, m1_txh, m1_tyl, m1_tyh;
  logic [PW-1:0] m1_bxh, m1_bxl, m1_byh, m1_byl;
  logic [NW-1:0] m2_tx, m2_ty, m2_bx, m2_by;
  logic [NW-1:0] m3_n [0:3];
  logic [NW-1:0] txm, tym, bxm, bym;
  logic tneg, bxneg, byneg;

  assign txm   = (NW'(m1_txh) << 32) + NW'(m1_txl);
  assign tym   = (NW'(m1_tyh) << 32) + NW'(m1_tyl);
  assign bxm   = (NW'(m1_bxh) << 33) + NW'(m1_bxl);
  assign bym   = (NW'(m1_byh) << 33) + NW'(m1_byl);
  assign tneg  = m1_g.dx[DW-1] ^ m1_g.dy[DW-1];
  assign bxneg = m1_g.d[D2W-1] ^ m1_g.dy[DW-1];
  assign byneg = !(m1_g.d[D2W-1] ^ m1_g.dx[DW-1]);

  logic [NW-1:0] dv_rem [0:3][0:QW];
  logic [QW-1:0] dv_q   [0:3][0:QW];
  logic          dv_neg [0:3][0:QW];
  clla_pkg::div_t dv_c  [0:QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_g   <= sq_geo[RW];
      m1_txl <= 65'(sq_geo[RW].adx) * 65'(sq_root[RW][31:0]);
      m1_txh <= 65'(sq_geo[RW].adx) * 65'(sq_root[RW][63:32]);
      m1_tyl <= 65'(sq_geo[RW].ady) * 65'(sq_root[RW][31:0]);
      m1_tyh <= 65'(sq_geo[RW].ady) * 65'(sq_root[RW][63:32]);
      m1_bxh <= PW'(sq_geo[RW].dabs[65:33]) * PW'(sq_geo[RW].ady);
      m1_bxl <= PW'(sq_geo[RW].dabs[32:0]) * PW'(sq_geo[RW].ady);
      m1_byh <= PW'(sq_geo[RW].dabs[65:33]) * PW'(sq_geo[RW].adx);
      m1_byl <= PW'(sq_geo[RW].dabs[32:0]) * PW'(sq_geo[RW].adx);

      m2_g  <= m1_g;
      m2_tx <= tneg  ? NW'(0) - txm : txm;
      m2_ty <= tym;
      m2_bx <= bxneg ? NW'(0) - bxm : bxm;
      m2_by <= byneg ? NW'(0) - bym : bym;

      m3_g    <= m2_g;
      m3_n[0] <= m2_bx + m2_tx;
      m3_n[1] <= m2_by + m2_ty;
      m3_n[2] <= m2_bx - m2_tx;
      m3_n[3] <= m2_by - m2_ty;

      dv_c[0].d2   <= m3_g.d2;
      dv_c[0].p2x  <= m3_g.p2x;
      dv_c[0].p2y  <= m3_g.p2y;
      dv_c[0].rx   <= m3_g.rx;
      dv_c[0].ry   <= m3_g.ry;
      dv_c[0].miss <= m3_g.miss;
    end
  end

  // rounded division, one quotient bit per stage in each lane
  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [NW-1:0] mag;
    assign mag = m3_n[l][NW-1] ? NW'(0) - m3_n[l] : m3_n[l];
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[l][0] <= mag + NW'(m3_g.d2 >> 1);
        dv_q[l][0]   <= '0;
        dv_neg[l][0] <= m3_n[l][NW-1];
      end
    end
    for (genvar j = 0; j < QW; j++) begin : g_step
      localparam int SH = QW - 1 - j;
      logic [NW-1:0] den;
      assign den = NW'(dv_c[j].d2) << SH;
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_neg[l][j+1] <= dv_neg[l][j];
          if (dv_rem[l][j] >= den) begin
            dv_rem[l][j+1] <= dv_rem[l][j] - den;
            dv_q[l][j+1]   <= dv_q[l][j] | (QW'(1) << SH);
          end else begin
            dv_rem[l][j+1] <= dv_rem[l][j];
            dv_q[l][j+1]   <= dv_q[l][j];
          end
        end
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_carry
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c[j+1] <= dv_c[j];
      end
    end
  end

  // root choice and output
  localparam int PTW = clla_pkg::PT_W;
  localparam int EXW = clla_pkg::EX_W;
  localparam int SDW = clla_pkg::SQD_W;

  logic [PTW-1:0] pt [0:3];
  logic [PTW-1:0] c1_pt [0:3];
  logic [EXW-1:0] c1_e  [0:3];
  logic [SDW-1:0] c2_s  [0:3];
  logic [PTW-1:0] c2_pt [0:3];
  clla_pkg::div_t c1_c, c2_c;
  logic [EXW-1:0] c3_sx, c3_sy;
  logic           c3_miss;
  logic [SDW:0]   dist1, dist2;
  logic           pick2;

  for (genvar l = 0; l < 4; l++) begin : g_pt
    assign pt[l] = dv_neg[l][QW] ? PTW'(0) - {1'b0, dv_q[l][QW]} : {1'b0, dv_q[l][QW]};
  end

  assign dist1 = (SDW+1)'(c2_s[0]) + (SDW+1)'(c2_s[1]);
  assign dist2 = (SDW+1)'(c2_s[2]) + (SDW+1)'(c2_s[3]);
  assign pick2 = dist2 < dist1;

  function automatic logic [clla_pkg::COORD_W-1:0] sat(input logic [EXW-1:0] v);
    logic [EXW-1:0] hi;
    logic [EXW-1:0] lo;
    hi = EXW'({1'b0, {(clla_pkg::COORD_W-1){1'b1}}});
    lo = ~hi;
    if (!v[EXW-1] && (v > hi)) begin
      sat = hi[clla_pkg::COORD_W-1:0];
    end else if (v[EXW-1] && (v < lo)) begin
      sat = lo[clla_pkg::COORD_W-1:0];
    end else begin
      sat = v[clla_pkg::COORD_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_c    <= dv_c[QW];
      c1_pt   <= pt;
      c1_e[0] <= EXW'($signed(pt[0])) - EXW'($signed(dv_c[QW].p2x));
      c1_e[1] <= EXW'($signed(pt[1])) - EXW'($signed(dv_c[QW].p2y));
      c1_e[2] <= EXW'($signed(pt[2])) - EXW'($signed(dv_c[QW].p2x));
      c1_e[3] <= EXW'($signed(pt[3])) - EXW'($signed(dv_c[QW].p2y));

      c2_c  <= c1_c;
      c2_pt <= c1_pt;
      for (int l = 0; l < 4; l++) begin
        c2_s[l] <= SDW'($signed(c1_e[l])) * SDW'($signed(c1_e[l]));
      end

      c3_miss <= c2_c.miss;
      c3_sx   <= EXW'($signed(pick2 ? c2_pt[2] : c2_pt[0])) + EXW'($signed(c2_c.rx));
      c3_sy   <= EXW'($signed(pick2 ? c2_pt[3] : c2_pt[1])) + EXW'($signed(c2_c.ry));

      out_item.hit     <= !c3_miss;
      out_item.point_x <= c3_miss ? clla_pkg::MISS_POINT : sat(c3_sx);
      out_item.point_y <= c3_miss ? clla_pkg::MISS_POINT : sat(c3_sy);
    end
  end

  assign out_valid = cv[3];

  a_miss_sentinel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.hit |->
      (out_item.point_x == clla_pkg::MISS_POINT) && (out_item.point_y == clla_pkg::MISS_POINT))
    else $error("miss result without sentinel point");

  a_root_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    sq_v[RW] && sq_geo[RW].miss |-> sq_root[RW] == '0)
    else $error("nonzero root for a missed line");

  a_rem_x1: assert property (@(posedge clk) disable iff (rst)
    dv_v[QW] && !dv_c[QW].miss |-> dv_rem[0][QW] < NW'(dv_c[QW].d2))
    else $error("x quotient overflowed its width");

  a_rem_y2: assert property (@(posedge clk) disable iff (rst)
    dv_v[QW] && !dv_c[QW].miss |-> dv_rem[3][QW] < NW'(dv_c[QW].d2))
    else $error("y quotient overflowed its width");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 130;
  localparam int RADW = clla_pkg::RAD_W;
  localparam logic signed [255:0] Q_CLAMP = 256'sd1 <<< 62;

  class lookahead_scoreboard;
    clla_pkg::out_item_t expected_points[$];
    int errors;
    int matched;

    function logic [255:0] floor_sqrt(logic [255:0] n);
      logic [255:0] res;
      logic [255:0] b;
      logic [255:0] t;
      res = '0;
      for (int k = 127; k >= 0; k--) begin
        b = 256'd1 << (2 * k);
        t = res + b;
        res = res >> 1;
        if (n >= t) begin
          n = n - t;
          res = res + b;
        end
      end
      return res;
    endfunction

    function logic signed [255:0] round_div(logic signed [255:0] n, logic signed [255:0] den);
      logic signed [255:0] mag;
      logic signed [255:0] q;
      mag = (n < 0) ? -n : n;
      q = (mag + (den >>> 1)) / den;
      if (q > Q_CLAMP) q = Q_CLAMP;
      return (n < 0) ? -q : q;
    endfunction

    function logic [clla_pkg::COORD_W-1:0] clamp_coord(logic signed [255:0] v);
      if (v > 256'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -256'sd2147483648) return 32'h8000_0000;
      return v[clla_pkg::COORD_W-1:0];
    endfunction

    function logic signed [255:0] dist_sq(logic signed [255:0] ax, logic signed [255:0] ay,
                                          logic signed [255:0] bx, logic signed [255:0] by);
      return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function clla_pkg::out_item_t lookahead_point(clla_pkg::in_item_t it,
                                                  logic [RADW-1:0] radius);
      logic signed [255:0] sx, sy, ex, ey, rx, ry, p1x, p1y, p2x, p2y, dx, dy, d2, bd, r, disc;
      logic signed [255:0] sq, sdx, ady, bx, by, tx, ty, x1, y1, x2, y2, cx, cy;
      clla_pkg::out_item_t o;
      sx = $signed(it.start_x);
      sy = $signed(it.start_y);
      ex = $signed(it.end_x);
      ey = $signed(it.end_y);
      rx = $signed(it.robot_x);
      ry = $signed(it.robot_y);
      p1x = sx - rx;
      p1y = sy - ry;
      p2x = ex - rx;
      p2y = ey - ry;
      dx = ex - sx;
      dy = ey - sy;
      d2 = dx * dx + dy * dy;
      bd = p1x * p2y - p2x * p1y;
      r = $signed({225'd0, radius});
      disc = r * r * d2 - bd * bd;
      if (d2 == 0 || disc < 0) begin
        o.point_x = clamp_coord(-(256'sd99 <<< clla_pkg::FRAC_BITS));
        o.point_y = clamp_coord(-(256'sd99 <<< clla_pkg::FRAC_BITS));
        o.hit = 1'b0;
        return o;
      end
      sq = $signed(floor_sqrt(disc));
      sdx = (dy < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      bx = bd * dy;
      by = -(bd * dx);
      tx = sdx * sq;
      ty = ady * sq;
      x1 = round_div(bx + tx, d2);
      y1 = round_div(by + ty, d2);
      x2 = round_div(bx - tx, d2);
      y2 = round_div(by - ty, d2);
      if (dist_sq(x2, y2, p2x, p2y) < dist_sq(x1, y1, p2x, p2y)) begin
        cx = x2;
        cy = y2;
      end else begin
        cx = x1;
        cy = y1;
      end
      o.point_x = clamp_coord(cx + rx);
      o.point_y = clamp_coord(cy + ry);
      o.hit = 1'b1;
      return o;
    endfunction

    function void note_segment(clla_pkg::in_item_t it, logic [RADW-1:0] radius);
      expected_points.push_back(lookahead_point(it, radius));
    endfunction

    function void check_point(clla_pkg::out_item_t got);
      clla_pkg::out_item_t e;
      if (expected_points.size() == 0) begin
        $error("unexpected result item: %h", got);
        errors++;
        return;
      end
      e = expected_points.pop_front();
      if (got.point_x !== e.point_x) begin
        $error("point_x: expected %h, actual %h", e.point_x, got.point_x);
        errors++;
      end
      if (got.point_y !== e.point_y) begin
        $error("point_y: expected %h, actual %h", e.point_y, got.point_y);
        errors++;
      end
      if (got.hit !== e.hit) begin
        $error("hit: expected %b, actual %b", e.hit, got.hit);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  clla_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  clla_pkg::out_item_t out_item;
  logic cfg_wr_en;
  logic [RADW-1:0] cfg_wr_data;

  lookahead_scoreboard sb;
  logic [RADW-1:0] radius_now;
  logic in_taken;
  logic out_taken;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  int hits_seen;

  circle_line_lookahead_point_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    out_taken = !rst && out_valid && !out_stall;
    if (in_taken) sb.note_segment(in_item, radius_now);
    if (out_taken) begin
      sb.check_point(out_item);
      if (out_item.hit) hits_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || in_taken || out_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic clla_pkg::in_item_t segment(int sx, int sy, int ex, int ey, int rx, int ry);
    clla_pkg::in_item_t it;
    it.start_x = sx;
    it.start_y = sy;
    it.end_x = ex;
    it.end_y = ey;
    it.robot_x = rx;
    it.robot_y = ry;
    return it;
  endfunction

  task automatic send_segment(clla_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_taken) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(logic [RADW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    radius_now = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int near_coord(int center, longint span);
    longint off;
    off = longint'($urandom_range(0, 32'hFFFF_FFFF)) % (2 * span + 1) - span;
    return int'(longint'(center) + off);
  endfunction

  function automatic clla_pkg::in_item_t random_segment();
    int rx, ry, sx, sy;
    longint span;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      return segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    rx = $signed($urandom) >>> $urandom_range(1, 12);
    ry = $signed($urandom) >>> $urandom_range(1, 12);
    span = 2 * longint'(radius_now) + 16;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    sx = near_coord(rx, span);
    sy = near_coord(ry, span);
    case (kind)
      8: return segment(sx, sy, sx, sy, rx, ry);
      9: begin
        if ($urandom_range(0, 1))
          return segment(sx, sy, near_coord(rx, span), sy, rx, ry);
        return segment(sx, sy, sx, near_coord(ry, span), rx, ry);
      end
      default: return segment(sx, sy, near_coord(rx, span), near_coord(ry, span), rx, ry);
    endcase
  endfunction

  localparam int ONE = 65536;
  localparam int MAXC = 32'h7FFF_FFFF;
  localparam int MINC = 32'h8000_0000;

  initial begin
    logic [RADW-1:0] radii [6];
    clla_pkg::in_item_t directed[$];
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    radius_now = clla_pkg::RADIUS_RESET;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(segment(-20 * ONE, 0, 20 * ONE, 0, 0, 0));
    directed.push_back(segment(20 * ONE, 0, -20 * ONE, 0, 0, 0));
    directed.push_back(segment(0, -20 * ONE, 0, 20 * ONE, 0, 0));
    directed.push_back(segment(0, 20 * ONE, 0, -20 * ONE, 0, 0));
    directed.push_back(segment(-5 * ONE, -3 * ONE, 7 * ONE, 9 * ONE, ONE, ONE));
    directed.push_back(segment(3 * ONE, 8 * ONE, -4 * ONE, -2 * ONE, 0, 0));
    directed.push_back(segment(-20 * ONE, 50 * ONE, 20 * ONE, 50 * ONE, 0, 0));
    directed.push_back(segment(5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 0, 0));
    directed.push_back(segment(0, 0, 0, 0, 0, 0));
    directed.push_back(segment(-20 * ONE, 12 * ONE, 20 * ONE, 12 * ONE, 0, 0));
    directed.push_back(segment(12 * ONE, -20 * ONE, 12 * ONE, 20 * ONE, 0, 0));
    directed.push_back(segment(MINC, MINC, MAXC, MAXC, 0, 0));
    directed.push_back(segment(MAXC, MINC, MINC, MAXC, MAXC, MINC));
    directed.push_back(segment(MAXC, MAXC, MAXC - 20 * ONE, MAXC, MAXC, MAXC));
    directed.push_back(segment(MINC, MINC, MINC + ONE, MINC, MINC, MINC));
    directed.push_back(segment(MINC, MAXC, MAXC, MINC, MINC, MINC));
    directed.push_back(segment(MAXC, MAXC, MINC, MINC, MAXC, MINC));
    directed.push_back(segment(1, 3, 7, -5, 2, 2));
    directed.push_back(segment(-1, -1, 1, 1, 0, 0));
    directed.push_back(segment(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                               32'h1234_5678, 32'hEDCB_A987));

    radii[0] = clla_pkg::RADIUS_RESET;
    radii[1] = 31'h7FFF_FFFF;
    radii[2] = '0;
    radii[3] = RADW'($urandom_range(1, 64 * ONE));
    radii[4] = RADW'(ONE / 2);
    radii[5] = RADW'($urandom);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 18;
          recv_stall_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_stall_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (ph != 0) write_radius(radii[ph]);
      foreach (directed[i]) send_segment(directed[i]);
      for (int n = 0; n < 240; n++) send_segment(random_segment());
      drain();
    end

    $display("Checked %0d result items (%0d hits) over 6 radius settings,", sb.matched,
             hits_seen);
    $display("including zero and full-scale radius, with sender and receiver idling.");
    if (sb.errors == 0 && sb.expected_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
